// ----- rtl/windowed_sample_average_assert.svh -----
// Assertion macros used by the checker file of the sample averager.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef WINDOWED_SAMPLE_AVERAGE_ASSERT_SVH
`define WINDOWED_SAMPLE_AVERAGE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("windowed_sample_average: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("windowed_sample_average: assertion failed");

`endif

// ----- rtl/wsa_pkg.sv -----
// Shared constants and types for the windowed sample averager.
// Used by every module of the block; depends on nothing.
`default_nettype none

package wsa_pkg;

  localparam int WINDOW      = 50;
  localparam int SAMPLE_W    = 16;
  localparam int MEAN_W      = 16;
  localparam int HELD_W      = 6;
  localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int TOTAL_W     = SAMPLE_W + CNT_W;
  localparam int STEP_W      = $clog2(TOTAL_W + 1);
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } wsa_state_t;

endpackage

`default_nettype wire

// ----- rtl/wsa_ring.sv -----
// Sample ring memory: one combined read and write access per cycle, read-first.
// Depends on wsa_pkg for depth and widths.
`default_nettype none

module wsa_ring (
  input  wire logic                          clk,
  input  wire logic                          acc_en,
  input  wire logic [wsa_pkg::SLOT_W-1:0]    addr,
  input  wire logic [wsa_pkg::SAMPLE_W-1:0]  wdata,
  output logic      [wsa_pkg::SAMPLE_W-1:0]  rdata
);
  import wsa_pkg::*;

  logic [SAMPLE_W-1:0] mem [WINDOW];
  logic [SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (acc_en) begin
      rdata_r    <= mem[addr];
      mem[addr]  <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/wsa_divider.sv -----
// Restoring divider producing one quotient bit per cycle.
// Depends on wsa_pkg for the dividend and divisor widths.
`default_nettype none

module wsa_divider (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [wsa_pkg::TOTAL_W-1:0]  dividend,
  input  wire logic [wsa_pkg::CNT_W-1:0]    divisor,
  output logic                              done,
  output logic      [wsa_pkg::TOTAL_W-1:0]  quotient
);
  import wsa_pkg::*;

  logic               busy_r;
  logic [STEP_W-1:0]  step_r;
  logic [CNT_W-1:0]   rem_r;
  logic [CNT_W-1:0]   div_r;
  logic [TOTAL_W-1:0] quo_r;
  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     diff;
  logic               ge;

  assign trial = {rem_r, quo_r[TOTAL_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(TOTAL_W);
    end else if (busy_r) begin
      step_r <= step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[TOTAL_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign done     = busy_r && (step_r == STEP_W'(1));
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/windowed_sample_average.sv -----
// Windowed sample averager: mean of the last WINDOW samples, one result per item.
// Each accepted item passes the states SUM, DIV and DONE; one item is in flight at a time.
// Throughput is set by the 22-step iterative divider; no new item is taken until DONE is left.
// The next item is accepted while a finished result still waits in the output register.
// Reset is synchronous: control, slot, count and total clear; the ring is not cleared.
`default_nettype none

module windowed_sample_average (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [wsa_pkg::IN_TDATA_W-1:0]   in_tdata,   // [15:0] sample_volts
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [wsa_pkg::OUT_TDATA_W-1:0]  out_tdata   // [15:0] mean_volts, [21:16] samples_held
);
  import wsa_pkg::*;

  wsa_state_t          state_r, state_nxt;
  logic [SLOT_W-1:0]   slot_r;
  logic [CNT_W-1:0]    count_r;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [SAMPLE_W-1:0] sample_r;
  logic                was_full_r;
  logic                out_valid_r;
  logic [MEAN_W-1:0]   mean_r;
  logic [HELD_W-1:0]   held_r;
  logic                accept;
  logic                div_start;
  logic                load_out;
  logic                div_done;
  logic [TOTAL_W-1:0]  quotient;
  logic [SAMPLE_W-1:0] old_sample;
  logic [TOTAL_W-1:0]  drop;

  assign accept = in_tvalid && in_tready;

  wsa_ring u_ring (
    .clk    (clk),
    .acc_en (accept),
    .addr   (slot_r),
    .wdata  (in_tdata[SAMPLE_W-1:0]),
    .rdata  (old_sample)
  );

  assign drop      = was_full_r ? TOTAL_W'(old_sample) : '0;
  assign total_nxt = total_r - drop + TOTAL_W'(sample_r);

  wsa_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_nxt),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    div_start = (state_r == ST_SUM);
    load_out  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        slot_r <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
        if (count_r != CNT_W'(WINDOW)) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (div_start) begin
        total_r <= total_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r   <= in_tdata[SAMPLE_W-1:0];
      was_full_r <= (count_r == CNT_W'(WINDOW));
    end
    if (load_out) begin
      mean_r <= MEAN_W'(quotient);
      held_r <= HELD_W'(count_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - MEAN_W - HELD_W)'(0), held_r, mean_r};

endmodule

`default_nettype wire

// ----- rtl/wsa_checker.sv -----
// Port-level checks for the windowed sample averager, bound to the top level.
// Depends on wsa_pkg and the assertion macros in windowed_sample_average_assert.svh.
`default_nettype none

`include "windowed_sample_average_assert.svh"

module wsa_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [wsa_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import wsa_pkg::*;

  `WSA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `WSA_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))
  `WSA_ASSERT_SAME(a_held_nonzero, out_tvalid, out_tdata[MEAN_W+HELD_W-1:MEAN_W] != '0)
  `WSA_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)

endmodule

bind windowed_sample_average wsa_checker u_wsa_checker (.*);

`default_nettype wire
